### design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, off while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

### design/rmscs_pkg.sv
package rmscs_pkg;

    // fixed field widths
    localparam int SAMPLE_W    = 12;
    localparam int ROOT_W      = 12;
    localparam int MEAN_W      = 2 * SAMPLE_W;
    localparam int DELAY_W     = 16;
    localparam int RUNTIME_W   = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    // samples per rms block; a power of two so the mean is a shift
    localparam int SAMPLES      = 64;
    localparam int SAMPLES_LOG2 = $clog2(SAMPLES);

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_START  = 2'd2,
        CMD_STOP   = 2'd3
    } t_cmd;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIR_INVERT    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_OFFSET = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LV_DELAY_MS   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IGNORE_OC_MS  = 3'd4;

    localparam logic [SAMPLE_W-1:0] CURRENT_LIMIT_RST = 12'd4095;
    localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET_RST = 12'd2048;
    localparam logic [DELAY_W-1:0]  LV_DELAY_RST      = 16'd100;
    localparam logic [DELAY_W-1:0]  IGNORE_OC_RST     = 16'd1000;

    typedef enum logic [1:0] {
        RMS_IDLE = 2'd0,
        RMS_ROOT = 2'd1
    } t_rms_state;

    typedef struct packed {
        logic                busy;
        logic                last;
        logic                done;
        logic [ROOT_W-1:0]   current;
    } t_rms_stat;

    typedef struct packed {
        logic                 tick;
        logic                 start;
        logic                 stop;
        logic                 sense_pin;
        logic [1:0]           dir_req;
        logic [RUNTIME_W-1:0] run_limit;
    } t_sup_cmd;

    typedef struct packed {
        logic [SAMPLE_W-1:0] current_limit;
        logic                dir_invert;
        logic [DELAY_W-1:0]  lv_delay;
        logic [DELAY_W-1:0]  ignore_oc;
    } t_sup_cfg;

    typedef struct packed {
        logic                 power_on;
        logic [1:0]           direction;
        logic                 dir_relay;
        logic [1:0]           last_direction;
        logic                 flt_lv;
        logic                 flt_ot;
        logic                 flt_oc;
        logic [ROOT_W-1:0]    peak;
        logic [RUNTIME_W-1:0] run_time;
    } t_sup_stat;

endpackage

### design/rmscs_cmpsub.sv
// shared compare/subtract: one borrow chain gives both a >= b and a - b
module rmscs_cmpsub #(
    parameter int W = 15
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ge,
    output logic [W-1:0] o_diff
);

    logic [W:0] sub;

    assign sub    = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~sub[W];
    assign o_diff = sub[W-1:0];

endmodule

### design/rmscs_rms.sv
// sample accumulator, mean by shift, digit-by-digit square root
module rmscs_rms #(
    parameter int ADC_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_smp,
    input  logic [rmscs_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [rmscs_pkg::SAMPLE_W-1:0]   i_offset,
    output rmscs_pkg::t_rms_stat             o_stat
);

    localparam int SW_   = rmscs_pkg::SAMPLE_W;
    localparam int MW    = rmscs_pkg::MEAN_W;
    localparam int RTW   = rmscs_pkg::ROOT_W;
    localparam int CW    = rmscs_pkg::SAMPLES_LOG2;
    localparam int SUM_W = MW + CW;
    localparam int REM_W = RTW + 3;
    localparam int STW   = $clog2(RTW);
    localparam logic [SW_-1:0] ADC_MASK =
        (ADC_BITS >= SW_) ? {SW_{1'b1}} : SW_'((1 << ADC_BITS) - 1);

    rmscs_pkg::t_rms_state r_state, n_state;
    logic [CW-1:0]    r_count;
    logic [SUM_W-1:0] r_sum;
    logic [REM_W-1:0] r_rem;
    logic [MW-1:0]    r_dq;          // radicand, shifted out two bits a step
    logic [RTW-1:0]   r_root;
    logic [STW-1:0]   r_step;
    logic [RTW-1:0]   r_current;

    logic [SW_-1:0]          smp;
    logic signed [SW_:0]     diff;
    logic signed [2*SW_+1:0] sq;
    logic [SUM_W-1:0]        sum_next;
    logic                    last;
    logic [REM_W-1:0]        rem_shift;
    logic [RTW+1:0]          trial;
    logic [REM_W-1:0]        cs_a, cs_b, cs_diff;
    logic                    cs_ge;
    logic                    busy, done;

    assign smp       = i_sample & ADC_MASK;
    assign diff      = $signed({1'b0, smp}) - $signed({1'b0, i_offset});
    assign sq        = diff * diff;
    assign sum_next  = r_sum + SUM_W'(sq[MW-1:0]);
    assign last      = (r_count == CW'(rmscs_pkg::SAMPLES - 1));
    assign rem_shift = {r_rem[REM_W-3:0], r_dq[MW-1 -: 2]};
    assign trial     = {r_root, 2'b01};

    rmscs_cmpsub #(.W(REM_W)) u_cs (
        .i_a    (cs_a),
        .i_b    (cs_b),
        .o_ge   (cs_ge),
        .o_diff (cs_diff)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmscs_pkg::RMS_IDLE: if (i_smp && last) n_state = rmscs_pkg::RMS_ROOT;
            rmscs_pkg::RMS_ROOT: if (r_step == '0) n_state = rmscs_pkg::RMS_IDLE;
            default:             n_state = rmscs_pkg::RMS_IDLE;
        endcase
    end

    always_comb begin
        cs_a = '0;
        cs_b = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (r_state)
            rmscs_pkg::RMS_IDLE: begin
                busy = 1'b0;
            end
            rmscs_pkg::RMS_ROOT: begin
                cs_a = rem_shift;
                cs_b = REM_W'(trial);
                done = (r_step == '0);
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rmscs_pkg::RMS_IDLE;
            r_count   <= '0;
            r_sum     <= '0;
            r_step    <= '0;
            r_current <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                rmscs_pkg::RMS_IDLE: begin
                    if (i_smp) begin
                        if (last) begin
                            // mean = sum / SAMPLES, a plain shift
                            r_count <= '0;
                            r_sum   <= '0;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_dq    <= sum_next[SUM_W-1:CW];
                            r_step  <= STW'(RTW - 1);
                        end else begin
                            r_count <= r_count + 1'b1;
                            r_sum   <= sum_next;
                        end
                    end
                end
                rmscs_pkg::RMS_ROOT: begin
                    r_rem  <= cs_ge ? cs_diff : rem_shift;
                    r_root <= {r_root[RTW-2:0], cs_ge};
                    r_dq   <= {r_dq[MW-3:0], 2'b00};
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) r_current <= {r_root[RTW-2:0], cs_ge};
                end
                default: ;
            endcase
        end
    end

    assign o_stat.busy    = busy;
    assign o_stat.last    = last;
    assign o_stat.done    = done;
    assign o_stat.current = r_current;

endmodule

### design/rmscs_supv.sv
// motor run state, time counters and fault flags
module rmscs_supv #(
    parameter int TIME_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rmscs_pkg::t_sup_cmd            i_cmd,
    input  rmscs_pkg::t_sup_cfg            i_cfg,
    input  logic [rmscs_pkg::ROOT_W-1:0]   i_current,
    output rmscs_pkg::t_sup_stat           o_stat
);

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic                 r_running, n_running;
    logic [1:0]           r_run_dir, n_run_dir;
    logic [1:0]           r_prev_dir, n_prev_dir;
    logic                 r_flt_lv, n_flt_lv;
    logic                 r_flt_ot, n_flt_ot;
    logic                 r_flt_oc, n_flt_oc;
    logic [TIME_BITS-1:0] r_sense_ms, n_sense_ms;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic [TIME_BITS-1:0] r_budget, n_budget;
    logic [rmscs_pkg::ROOT_W-1:0] r_peak, n_peak;

    logic       dir_ok, refuse;
    logic [1:0] relay_base;

    assign dir_ok = (i_cmd.dir_req == rmscs_pkg::DIR_FWD) ||
                    (i_cmd.dir_req == rmscs_pkg::DIR_REV);
    assign refuse = !dir_ok || r_flt_lv || (r_running && (i_cmd.dir_req == r_run_dir));

    always_comb begin
        n_running  = r_running;
        n_run_dir  = r_run_dir;
        n_prev_dir = r_prev_dir;
        n_flt_lv   = r_flt_lv;
        n_flt_ot   = r_flt_ot;
        n_flt_oc   = r_flt_oc;
        n_sense_ms = r_sense_ms;
        n_elapsed  = r_elapsed;
        n_budget   = r_budget;
        n_peak     = r_peak;

        if (i_cmd.tick) begin
            // mains check first
            if (!i_cmd.sense_pin) begin
                n_sense_ms = '0;
                n_flt_lv   = 1'b0;
            end else if (r_sense_ms != TIME_MAX) begin
                n_sense_ms = r_sense_ms + 1'b1;
            end
            if ((n_sense_ms > TIME_BITS'(i_cfg.lv_delay)) && !n_flt_lv) begin
                n_flt_lv = 1'b1;
                if (n_running) begin
                    n_running  = 1'b0;
                    n_prev_dir = n_run_dir;
                    n_run_dir  = rmscs_pkg::DIR_NONE;
                end
            end
            // run time, then peak / overcurrent on the same count
            if (n_running) begin
                if (r_elapsed != TIME_MAX) n_elapsed = r_elapsed + 1'b1;
                if (n_elapsed > r_budget) begin
                    n_flt_ot   = 1'b1;
                    n_running  = 1'b0;
                    n_prev_dir = n_run_dir;
                    n_run_dir  = rmscs_pkg::DIR_NONE;
                end
                if (n_elapsed > TIME_BITS'(i_cfg.ignore_oc)) begin
                    if (i_current > r_peak) n_peak = i_current;
                    if (i_current > i_cfg.current_limit) begin
                        n_flt_oc = 1'b1;
                        if (n_running) begin
                            n_running  = 1'b0;
                            n_prev_dir = n_run_dir;
                            n_run_dir  = rmscs_pkg::DIR_NONE;
                        end
                    end
                end
            end
        end else if (i_cmd.start) begin
            if (!refuse) begin
                if (r_running) n_prev_dir = r_run_dir;   // reverse: record the old direction
                n_running = 1'b1;
                n_run_dir = i_cmd.dir_req;
                n_elapsed = '0;
                n_budget  = TIME_BITS'(i_cmd.run_limit);
            end
        end else if (i_cmd.stop) begin
            if (r_running) begin
                n_running  = 1'b0;
                n_prev_dir = r_run_dir;
                n_run_dir  = rmscs_pkg::DIR_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_run_dir  <= rmscs_pkg::DIR_NONE;
            r_prev_dir <= rmscs_pkg::DIR_NONE;
            r_flt_lv   <= 1'b0;
            r_flt_ot   <= 1'b0;
            r_flt_oc   <= 1'b0;
            r_sense_ms <= '0;
            r_elapsed  <= '0;
            r_budget   <= '0;
            r_peak     <= '0;
        end else begin
            r_running  <= n_running;
            r_run_dir  <= n_run_dir;
            r_prev_dir <= n_prev_dir;
            r_flt_lv   <= n_flt_lv;
            r_flt_ot   <= n_flt_ot;
            r_flt_oc   <= n_flt_oc;
            r_sense_ms <= n_sense_ms;
            r_elapsed  <= n_elapsed;
            r_budget   <= n_budget;
            r_peak     <= n_peak;
        end
    end

    assign relay_base = r_run_dir - rmscs_pkg::DIR_FWD;

    assign o_stat.power_on       = r_running;
    assign o_stat.direction      = r_run_dir;
    assign o_stat.dir_relay      = r_running & (relay_base[0] ^ i_cfg.dir_invert);
    assign o_stat.last_direction = r_prev_dir;
    assign o_stat.flt_lv         = r_flt_lv;
    assign o_stat.flt_ot         = r_flt_ot;
    assign o_stat.flt_oc         = r_flt_oc;
    assign o_stat.peak           = r_peak;
    assign o_stat.run_time       = rmscs_pkg::RUNTIME_W'(r_elapsed);

endmodule

### design/motor_rms_current_supervisor.sv
// Channel      | Dir | Handshake                        | Content
// s_axis       | in  | tvalid/tready                    | one command per transaction
// m_axis       | out | tvalid/tready                    | one status result per command
// APB          | in  | psel/penable/pwrite, pready = 1  | five config registers at 4*i
//
// Tick, start, stop and non-final samples: result is valid the cycle after the
// transaction. The sample that closes a block takes the mean as a shift by
// log2(SAMPLES), then runs the shared compare/subtract unit for ROOT_W (12) root
// steps; the result is registered after the last step, input held off meanwhile.
// Input is also held off while a result waits on m_axis and does not leave that
// cycle. Reset is synchronous, active low; no clearing pass.
module motor_rms_current_supervisor #(
    parameter int ADC_BITS  = 12,
    parameter int TIME_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [11:0] sample, [12] sense_pin, [14:13] dir_req, [38:15] run_limit_ms, [39] zero
    input  logic [rmscs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] power_on, [2:1] direction, [3] dir_relay, [5:4] last_direction,
    // [6] fault_low_voltage, [7] fault_overtime, [8] fault_overcurrent,
    // [20:9] rms_current, [32:21] peak_current, [56:33] run_time_ms, [63:57] zero
    output logic [rmscs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] rms_new
    output logic [0:0]                            m_axis_tuser,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rmscs_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rmscs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rmscs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    // config registers
    logic [rmscs_pkg::SAMPLE_W-1:0] r_current_limit;
    logic                           r_dir_invert;
    logic [rmscs_pkg::SAMPLE_W-1:0] r_sample_offset;
    logic [rmscs_pkg::DELAY_W-1:0]  r_lv_delay;
    logic [rmscs_pkg::DELAY_W-1:0]  r_ignore_oc;

    // result handshake state; the payload is the live state of the sub-blocks,
    // which moves on an accepted command, a finished root or an APB write
    logic r_out_valid, n_out_valid;
    logic r_rms_new, n_rms_new;

    logic                               accept;
    logic                               apb_wr;
    logic [rmscs_pkg::REG_IDX_W-1:0]    reg_idx;
    rmscs_pkg::t_cmd                    cmd;
    rmscs_pkg::t_rms_stat               rms;
    rmscs_pkg::t_sup_cmd                sup_cmd;
    rmscs_pkg::t_sup_cfg                sup_cfg;
    rmscs_pkg::t_sup_stat               sup;
    logic                               blk_end;

    assign cmd     = rmscs_pkg::t_cmd'(s_axis_tuser);
    assign accept  = s_axis_tvalid & s_axis_tready;
    assign blk_end = (cmd == rmscs_pkg::CMD_SAMPLE) & rms.last;

    // a waiting result blocks input unless it leaves this cycle, as does a root in progress
    assign s_axis_tready = !rms.busy && (!r_out_valid || m_axis_tready);

    // ---------------- APB ----------------
    assign pready  = 1'b1;
    assign apb_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[rmscs_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_limit <= rmscs_pkg::CURRENT_LIMIT_RST;
            r_dir_invert    <= 1'b0;
            r_sample_offset <= rmscs_pkg::SAMPLE_OFFSET_RST;
            r_lv_delay      <= rmscs_pkg::LV_DELAY_RST;
            r_ignore_oc     <= rmscs_pkg::IGNORE_OC_RST;
        end else if (apb_wr) begin
            unique case (reg_idx)
                rmscs_pkg::REG_CURRENT_LIMIT: r_current_limit <= pwdata[rmscs_pkg::SAMPLE_W-1:0];
                rmscs_pkg::REG_DIR_INVERT:    r_dir_invert    <= pwdata[0];
                rmscs_pkg::REG_SAMPLE_OFFSET: r_sample_offset <= pwdata[rmscs_pkg::SAMPLE_W-1:0];
                rmscs_pkg::REG_LV_DELAY_MS:   r_lv_delay      <= pwdata[rmscs_pkg::DELAY_W-1:0];
                rmscs_pkg::REG_IGNORE_OC_MS:  r_ignore_oc     <= pwdata[rmscs_pkg::DELAY_W-1:0];
                default: ;  // unmapped: dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rmscs_pkg::REG_CURRENT_LIMIT: prdata = rmscs_pkg::APB_DATA_W'(r_current_limit);
            rmscs_pkg::REG_DIR_INVERT:    prdata = rmscs_pkg::APB_DATA_W'(r_dir_invert);
            rmscs_pkg::REG_SAMPLE_OFFSET: prdata = rmscs_pkg::APB_DATA_W'(r_sample_offset);
            rmscs_pkg::REG_LV_DELAY_MS:   prdata = rmscs_pkg::APB_DATA_W'(r_lv_delay);
            rmscs_pkg::REG_IGNORE_OC_MS:  prdata = rmscs_pkg::APB_DATA_W'(r_ignore_oc);
            default:                      prdata = '0;
        endcase
    end

    // ---------------- RMS path ----------------
    rmscs_rms #(
        .ADC_BITS (ADC_BITS)
    ) u_rms (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp    (accept && (cmd == rmscs_pkg::CMD_SAMPLE)),
        .i_sample (s_axis_tdata[11:0]),
        .i_offset (r_sample_offset),
        .o_stat   (rms)
    );

    // ---------------- motor supervision ----------------
    assign sup_cmd.tick      = accept && (cmd == rmscs_pkg::CMD_TICK);
    assign sup_cmd.start     = accept && (cmd == rmscs_pkg::CMD_START);
    assign sup_cmd.stop      = accept && (cmd == rmscs_pkg::CMD_STOP);
    assign sup_cmd.sense_pin = s_axis_tdata[12];
    assign sup_cmd.dir_req   = s_axis_tdata[14:13];
    assign sup_cmd.run_limit = s_axis_tdata[38:15];

    assign sup_cfg.current_limit = r_current_limit;
    assign sup_cfg.dir_invert    = r_dir_invert;
    assign sup_cfg.lv_delay      = r_lv_delay;
    assign sup_cfg.ignore_oc     = r_ignore_oc;

    rmscs_supv #(
        .TIME_BITS (TIME_BITS)
    ) u_supv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (sup_cmd),
        .i_cfg     (sup_cfg),
        .i_current (rms.current),
        .o_stat    (sup)
    );

    // ---------------- result handshake ----------------
    always_comb begin
        n_out_valid = r_out_valid;
        n_rms_new   = r_rms_new;
        if (m_axis_tvalid && m_axis_tready) n_out_valid = 1'b0;
        if (accept) begin
            n_rms_new = 1'b0;
            if (!blk_end) n_out_valid = 1'b1;
        end
        if (rms.done) begin     // block closed: new rms value
            n_out_valid = 1'b1;
            n_rms_new   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rms_new   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_rms_new   <= n_rms_new;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_rms_new;
    assign m_axis_tdata  = {7'd0,
                            sup.run_time,
                            sup.peak,
                            rms.current,
                            sup.flt_oc,
                            sup.flt_ot,
                            sup.flt_lv,
                            sup.last_direction,
                            sup.dir_relay,
                            sup.direction,
                            sup.power_on};

endmodule

### design/rmscs_checker.sv
`include "assert_macros.svh"

module rmscs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [1:0]                         s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [rmscs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // a stalled result holds off new commands
    `ASSERT_IMPLIES(a_stall_blocks_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

    // control commands answer in the next cycle
    `ASSERT_NEXT(a_ctrl_result_next, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser != rmscs_pkg::CMD_SAMPLE), m_axis_tvalid)

    // stop always leaves the motor off
    `ASSERT_NEXT(a_stop_powers_off, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == rmscs_pkg::CMD_STOP), !m_axis_tdata[0])

    // overtime fault stays until reset
    `ASSERT_NEXT(a_overtime_sticky, i_clk, i_rst_n, m_axis_tdata[7], m_axis_tdata[7])

endmodule

bind motor_rms_current_supervisor rmscs_checker u_rmscs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
